// ----- hw/rtl/mtu_pkg.sv -----
// Shared types and constants for the 3x3 matrix transform unit.
// Used by the front stage, the job queue, the execution back end and the top level.
`timescale 1ns / 1ps

package mtu_pkg;

  // Fixed-point format of every word.
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int NUM_ELEM  = 9;
  localparam int NUM_LANE  = 3;

  // Saturation bounds, held at product width.
  localparam logic signed [PROD_W-1:0] WORD_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] WORD_MIN = -PROD_W'(64'sd2147483648);

  // The value one in Q format, used to pass load words through the multipliers.
  localparam logic signed [WORD_W-1:0] Q_ONE = WORD_W'(1) << FRAC_BITS;

  typedef logic signed [WORD_W-1:0] word_t;

  // Operation codes, same encoding as the command field.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MUL  = 2'd1,
    OP_TMUL = 2'd2,
    OP_ROT  = 2'd3
  } op_t;

  // One input item as it arrives on the command channel.
  typedef struct packed {
    logic [1:0] command;
    word_t      elem_0;
    word_t      elem_1;
    word_t      elem_2;
    word_t      elem_3;
    word_t      elem_4;
    word_t      elem_5;
    word_t      elem_6;
    word_t      elem_7;
    word_t      elem_8;
  } in_item_t;

  // One result item as it leaves on the result channel.
  typedef struct packed {
    word_t out_0;
    word_t out_1;
    word_t out_2;
    word_t out_3;
    word_t out_4;
    word_t out_5;
    word_t out_6;
    word_t out_7;
    word_t out_8;
    logic  saturated;
  } out_item_t;

  // A classified item as held in the queue between front and back.
  typedef struct packed {
    op_t                                op;
    logic [NUM_ELEM-1:0][WORD_W-1:0]    elem;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ----- hw/rtl/mtu_front.sv -----
// Front stage of the matrix transform unit: accepts items and classifies them.
// Depends on mtu_pkg; feeds mtu_queue.
`timescale 1ns / 1ps

module mtu_front import mtu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  in_item_t  cmd_item,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_job
);

  logic f_valid;
  job_t f_job;
  logic take;
  logic moved;

  // The held item moves on whenever the queue has room.
  assign moved     = f_valid && !q_status.full;
  assign cmd_stall = f_valid && q_status.full;
  assign take      = cmd_valid && !cmd_stall;
  assign push      = moved;
  assign push_job  = f_job;

  // Valid flag of the front register.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (moved) begin
      f_valid <= 1'b0;
    end
  end

  // Decode the command and pack the operands in row-major order.
  always_ff @(posedge clk) begin
    if (take) begin
      f_job.op      <= op_t'(cmd_item.command);
      f_job.elem[0] <= cmd_item.elem_0;
      f_job.elem[1] <= cmd_item.elem_1;
      f_job.elem[2] <= cmd_item.elem_2;
      f_job.elem[3] <= cmd_item.elem_3;
      f_job.elem[4] <= cmd_item.elem_4;
      f_job.elem[5] <= cmd_item.elem_5;
      f_job.elem[6] <= cmd_item.elem_6;
      f_job.elem[7] <= cmd_item.elem_7;
      f_job.elem[8] <= cmd_item.elem_8;
    end
  end

endmodule

// ----- hw/rtl/mtu_queue.sv -----
// Two-entry job queue between the front stage and the back end.
// Depends on mtu_pkg.
`timescale 1ns / 1ps

module mtu_queue import mtu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t q_status
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_status.full      = (count == 2'd2);
  assign q_status.not_empty = (count != 2'd0);
  assign do_push            = push && !q_status.full;
  assign do_pop             = pop && q_status.not_empty;
  assign head_job           = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/mtu_back.sv -----
// Execution back end: holds the matrix, runs three multiply lanes a row at a time,
// sums and saturates, and keeps the result register. Depends on mtu_pkg.
`timescale 1ns / 1ps

module mtu_back import mtu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head_job,
  input  q_status_t q_status,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  // Matrix state, row-major.
  word_t mat [NUM_ELEM];

  // Issue control.
  logic [1:0] row_cnt;
  logic       issue;
  logic       p_free;

  // Product stage.
  logic                     p_valid;
  logic                     p_last;
  logic                     p_rot;
  logic signed [PROD_W-1:0] prod [NUM_LANE][NUM_LANE];

  // Sum stage.
  logic                     s_adv;
  logic                     s_hold;
  logic signed [PROD_W-1:0] sum  [NUM_LANE];
  word_t                    lane_word [NUM_LANE];
  logic [NUM_LANE-1:0]      lane_sat;

  // Earlier rows of the item in flight.
  word_t stage_word [2*NUM_LANE];
  logic  stage_sat;

  // Operand selection.
  word_t m_row [NUM_LANE];
  word_t r_row [NUM_LANE];
  word_t r_col [NUM_LANE];
  word_t op_a  [NUM_LANE][NUM_LANE];
  word_t op_b  [NUM_LANE][NUM_LANE];
  word_t res_word [NUM_ELEM];
  word_t rv [NUM_ELEM];

  // The last row waits in the sum stage while the result register is stalled.
  assign s_hold = p_valid && p_last && res_valid && res_stall;
  assign s_adv  = p_valid && !s_hold;
  assign p_free = !p_valid || s_adv;
  // A new item starts only once the previous one has written the matrix back.
  assign issue  = q_status.not_empty && p_free && ((row_cnt != 2'd0) || !p_valid);
  assign pop    = issue && (row_cnt == 2'd2);

  // Row slices of the matrix and of the operand for the row being issued.
  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      rv[i] = $signed(head_job.elem[i]);
    end
    for (int k = 0; k < NUM_LANE; k++) begin
      m_row[k] = '0;
      r_row[k] = '0;
      r_col[k] = '0;
    end
    unique case (row_cnt)
      2'd0: begin
        for (int k = 0; k < NUM_LANE; k++) begin
          m_row[k] = mat[k];
          r_row[k] = rv[k];
          r_col[k] = rv[3*k];
        end
      end
      2'd1: begin
        for (int k = 0; k < NUM_LANE; k++) begin
          m_row[k] = mat[3+k];
          r_row[k] = rv[3+k];
          r_col[k] = rv[3*k+1];
        end
      end
      2'd2: begin
        for (int k = 0; k < NUM_LANE; k++) begin
          m_row[k] = mat[6+k];
          r_row[k] = rv[6+k];
          r_col[k] = rv[3*k+2];
        end
      end
      default: begin
        for (int k = 0; k < NUM_LANE; k++) begin
          m_row[k] = '0;
        end
      end
    endcase
  end

  // Lane j, term k operands for the current operation.
  always_comb begin
    for (int j = 0; j < NUM_LANE; j++) begin
      for (int k = 0; k < NUM_LANE; k++) begin
        unique case (head_job.op)
          OP_LOAD: begin
            op_a[j][k] = (k == 0) ? r_row[j] : '0;
            op_b[j][k] = Q_ONE;
          end
          OP_MUL: begin
            op_a[j][k] = m_row[k];
            op_b[j][k] = rv[3*k+j];
          end
          OP_TMUL: begin
            op_a[j][k] = r_col[k];
            op_b[j][k] = mat[3*k+j];
          end
          OP_ROT: begin
            op_a[j][k] = (row_cnt == 2'd0) ? mat[3*k+j] : '0;
            op_b[j][k] = rv[k];
          end
          default: begin
            op_a[j][k] = '0;
            op_b[j][k] = '0;
          end
        endcase
      end
    end
  end

  // Issue counter and product stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= 2'd0;
      p_valid <= 1'b0;
    end else begin
      if (issue) begin
        row_cnt <= (row_cnt == 2'd2) ? 2'd0 : row_cnt + 2'd1;
        p_valid <= 1'b1;
      end else if (s_adv) begin
        p_valid <= 1'b0;
      end
    end
  end

  // Nine multipliers, registered.
  always_ff @(posedge clk) begin
    if (issue) begin
      p_last <= (row_cnt == 2'd2);
      p_rot  <= (head_job.op == OP_ROT);
      for (int j = 0; j < NUM_LANE; j++) begin
        for (int k = 0; k < NUM_LANE; k++) begin
          prod[j][k] <= PROD_W'(op_a[j][k]) * PROD_W'(op_b[j][k]);
        end
      end
    end
  end

  // Shift each product down to Q format, add the three terms and saturate.
  always_comb begin
    for (int j = 0; j < NUM_LANE; j++) begin
      sum[j] = (prod[j][0] >>> FRAC_BITS) + (prod[j][1] >>> FRAC_BITS)
             + (prod[j][2] >>> FRAC_BITS);
      if (sum[j] > WORD_MAX) begin
        lane_word[j] = WORD_MAX[WORD_W-1:0];
        lane_sat[j]  = 1'b1;
      end else if (sum[j] < WORD_MIN) begin
        lane_word[j] = WORD_MIN[WORD_W-1:0];
        lane_sat[j]  = 1'b1;
      end else begin
        lane_word[j] = sum[j][WORD_W-1:0];
        lane_sat[j]  = 1'b0;
      end
    end
  end

  // Full result of the item: two staged rows and the row in the sum stage.
  always_comb begin
    for (int i = 0; i < 2*NUM_LANE; i++) begin
      res_word[i] = stage_word[i];
    end
    for (int j = 0; j < NUM_LANE; j++) begin
      res_word[2*NUM_LANE+j] = lane_word[j];
    end
  end

  // Collect the first two rows; row index follows the product stage order.
  // While the first row sits in the product stage the counter already reads one.
  always_ff @(posedge clk) begin
    if (s_adv && !p_last) begin
      for (int j = 0; j < NUM_LANE; j++) begin
        stage_word[j]          <= stage_word[NUM_LANE+j];
        stage_word[NUM_LANE+j] <= lane_word[j];
      end
      stage_sat <= (row_cnt == 2'd1) ? (|lane_sat) : (stage_sat | (|lane_sat));
    end
  end

  // Matrix write-back at the end of an item; rotate leaves it unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        mat[i] <= '0;
      end
    end else if (s_adv && p_last && !p_rot) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        mat[i] <= res_word[i];
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_adv && p_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s_adv && p_last) begin
      res_item.out_0     <= res_word[0];
      res_item.out_1     <= res_word[1];
      res_item.out_2     <= res_word[2];
      res_item.out_3     <= res_word[3];
      res_item.out_4     <= res_word[4];
      res_item.out_5     <= res_word[5];
      res_item.out_6     <= res_word[6];
      res_item.out_7     <= res_word[7];
      res_item.out_8     <= res_word[8];
      res_item.saturated <= stage_sat | (|lane_sat);
    end
  end

endmodule

// ----- hw/rtl/matrix3_transform_unit_core.sv -----
// Matrix transform unit top level: front stage, two-entry job queue, execution back end.
// An item passes through the front register, a queue slot, the product register and
// the result register. Its three rows issue back to back through the nine multipliers,
// and the next item waits until the item before it has written the matrix back.
// Reset (synchronous, active high) clears the matrix to zero and empties all stages.
`timescale 1ns / 1ps

module matrix3_transform_unit_core import mtu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  in_item_t  cmd_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head_job;
  q_status_t q_status;

  // Accept and classify items.
  mtu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  // Decouple the front from the back.
  mtu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  // Carry out the matrix operations.
  mtu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ----- tb/sv/matrix3_transform_unit_checker.sv -----
// Result checker for the 3x3 matrix transform unit: tracks the matrix, predicts each result.
// Watches the command and result channels and compares every result word by word.
// Depends on mtu_pkg for the item types, the Q format and the saturation bounds.
`timescale 1ns / 1ps

module matrix3_transform_unit_checker import mtu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  in_item_t  cmd_item,
  input  logic      res_valid,
  input  logic      res_stall,
  input  out_item_t res_item,
  output int        fail_count,
  output int        pending
);

  // Word i of an item sits below word i-1; the command field is above elem_0.
  localparam int IN_TOP  = $bits(in_item_t) - 3;
  localparam int OUT_TOP = $bits(out_item_t) - 1;

  typedef logic [NUM_ELEM-1:0][WORD_W-1:0] matrix_t;

  matrix_t   matrix_model;
  out_item_t transform_q[$];
  out_item_t expected;
  word_t     exp_word;
  word_t     act_word;
  int        errors;
  int        k;

  // One Q16.16 dot product of three terms: each product floored by the fraction
  // shift, then the exact sum clamped to the word range. The top bit flags a clamp.
  function automatic logic [WORD_W:0] dot_q16(input word_t a0, input word_t b0,
                                              input word_t a1, input word_t b1,
                                              input word_t a2, input word_t b2);
    longint sum;
    sum = ((longint'(a0) * longint'(b0)) >>> FRAC_BITS)
        + ((longint'(a1) * longint'(b1)) >>> FRAC_BITS)
        + ((longint'(a2) * longint'(b2)) >>> FRAC_BITS);
    if (sum > WORD_MAX) return {1'b1, word_t'(WORD_MAX)};
    if (sum < WORD_MIN) return {1'b1, word_t'(WORD_MIN)};
    return {1'b0, word_t'(sum)};
  endfunction

  // Result of one item given the matrix as it stood before the item.
  function automatic out_item_t transform_result(input in_item_t it, input matrix_t m);
    word_t           r [NUM_ELEM];
    logic [WORD_W:0] d;
    out_item_t       o;
    logic            sat;
    int              i;
    int              j;
    o   = '0;
    sat = 1'b0;
    for (i = 0; i < NUM_ELEM; i++) r[i] = it[IN_TOP - WORD_W*i -: WORD_W];
    case (op_t'(it.command))
      OP_LOAD: begin
        for (i = 0; i < NUM_ELEM; i++) o[OUT_TOP - WORD_W*i -: WORD_W] = r[i];
      end
      OP_MUL: begin
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++) begin
            d = dot_q16(m[3*i], r[j], m[3*i+1], r[3+j], m[3*i+2], r[6+j]);
            sat = sat | d[WORD_W];
            o[OUT_TOP - WORD_W*(3*i+j) -: WORD_W] = d[WORD_W-1:0];
          end
      end
      OP_TMUL: begin
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++) begin
            d = dot_q16(r[i], m[j], r[3+i], m[3+j], r[6+i], m[6+j]);
            sat = sat | d[WORD_W];
            o[OUT_TOP - WORD_W*(3*i+j) -: WORD_W] = d[WORD_W-1:0];
          end
      end
      default: begin
        // Rotate: transpose of M times the vector, the other six words stay zero.
        for (i = 0; i < 3; i++) begin
          d = dot_q16(m[i], r[0], m[3+i], r[1], m[6+i], r[2]);
          sat = sat | d[WORD_W];
          o[OUT_TOP - WORD_W*i -: WORD_W] = d[WORD_W-1:0];
        end
      end
    endcase
    o.saturated = sat;
    return o;
  endfunction

  // Predict on every accepted command item, compare on every accepted result item.
  always @(posedge clk) begin
    if (rst) begin
      matrix_model = '0;
      transform_q.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        expected = transform_result(cmd_item, matrix_model);
        if (op_t'(cmd_item.command) != OP_ROT)
          for (k = 0; k < NUM_ELEM; k++)
            matrix_model[k] = expected[OUT_TOP - WORD_W*k -: WORD_W];
        transform_q.push_back(expected);
      end
      if (res_valid && !res_stall) begin
        if (transform_q.size() == 0) begin
          $error("result item arrived with no item outstanding");
          errors++;
        end else begin
          expected = transform_q.pop_front();
          for (k = 0; k < NUM_ELEM; k++) begin
            exp_word = expected[OUT_TOP - WORD_W*k -: WORD_W];
            act_word = res_item[OUT_TOP - WORD_W*k -: WORD_W];
            if (exp_word !== act_word) begin
              $error("out_%0d mismatch: expected %0d, actual %0d", k, exp_word, act_word);
              errors++;
            end
          end
          if (expected.saturated !== res_item.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b",
                   expected.saturated, res_item.saturated);
            errors++;
          end
        end
      end
    end
    pending    <= transform_q.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/sv/matrix3_transform_unit_core_tb.sv -----
// Testbench top for the 3x3 matrix transform unit: clock, reset, stimulus and verdict.
// Drives directed and random command items with bursty pacing and a stalling receiver.
// Depends on mtu_pkg, matrix3_transform_unit_core and matrix3_transform_unit_checker.
`timescale 1ns / 1ps

module matrix3_transform_unit_core_tb;
  import mtu_pkg::*;

  localparam int IN_TOP         = $bits(in_item_t) - 3;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_ITEMS    = 260;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam word_t W_MAX  = 32'sh7fff_ffff;
  localparam word_t W_MIN  = 32'sh8000_0000;
  localparam word_t Q_HALF = Q_ONE >>> 1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  in_item_t    cmd_item = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  out_item_t   res_item;
  int          fail_count;
  int          pending;

  int          burst_left = 0;
  int          max_gap = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;

  always #5 clk = ~clk;

  matrix3_transform_unit_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  matrix3_transform_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Operand words: mostly small Q16.16 values so products stay in range for a while,
  // with corner values and raw 32-bit patterns mixed in.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      4, 5:       return word_t'($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
      6: begin
        case ($urandom_range(0, 6))
          0:       return W_MIN;
          1:       return W_MAX;
          2:       return 32'sd0;
          3:       return -32'sd1;
          4:       return 32'sd1;
          5:       return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_item(input op_t op);
    in_item_t it;
    int       i;
    it.command = op;
    for (i = 0; i < NUM_ELEM; i++) it[IN_TOP - WORD_W*i -: WORD_W] = rand_word();
    return it;
  endfunction

  function automatic in_item_t uniform_item(input op_t op, input word_t v);
    in_item_t it;
    int       i;
    it.command = op;
    for (i = 0; i < NUM_ELEM; i++) it[IN_TOP - WORD_W*i -: WORD_W] = v;
    return it;
  endfunction

  // Diagonal words are 0, 4 and 8 in row-major order.
  function automatic in_item_t diag_item(input op_t op, input word_t d, input word_t off);
    in_item_t it;
    int       i;
    it.command = op;
    for (i = 0; i < NUM_ELEM; i++) it[IN_TOP - WORD_W*i -: WORD_W] = (i % 4 == 0) ? d : off;
    return it;
  endfunction

  // Rotate item; the six words past the vector carry noise the block must ignore.
  function automatic in_item_t vec_item(input word_t x, input word_t y, input word_t z);
    in_item_t it;
    it = rand_item(OP_ROT);
    it.elem_0 = x;
    it.elem_1 = y;
    it.elem_2 = z;
    return it;
  endfunction

  // Present one item, hold it until taken, then keep the burst going or idle a while.
  task automatic send_item(input in_item_t it);
    cmd_item  <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      if (max_gap > 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk);
      end
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver stall pattern, switching to a random mode each time its hold count runs out.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_hold <= $urandom_range(20, 200);
      end else begin
        stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
        STALL_NONE:  res_stall <= 1'b0;
        STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
        default:     res_stall <= (stall_hold % 8 < 5);
      endcase
    end
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix3_transform_unit_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int sent;
    int seq_len;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items: reset matrix, corner words, rounding and saturation.
    max_gap = 2;
    send_item(vec_item(Q_ONE, -Q_ONE, W_MAX));
    send_item(uniform_item(OP_LOAD, W_MAX));
    send_item(uniform_item(OP_LOAD, W_MIN));
    send_item(diag_item(OP_LOAD, Q_ONE, 32'sd0));
    send_item(vec_item(W_MAX, W_MIN, -32'sd1));
    send_item(diag_item(OP_MUL, Q_ONE, 32'sd0));
    send_item(diag_item(OP_MUL, 32'sh2_0000, Q_HALF));
    send_item(diag_item(OP_TMUL, Q_ONE, -Q_HALF));
    send_item(vec_item(32'sh3_8000, -32'sh2_4000, 32'sh0_2000));
    // Floor rounding of tiny negative products.
    send_item(uniform_item(OP_LOAD, -32'sd1));
    send_item(uniform_item(OP_MUL, 32'sd1));
    send_item(vec_item(32'sd1, 32'sd1, 32'sd1));
    // Saturation: each term in range but the sum of three clamps, then terms out of range.
    send_item(uniform_item(OP_LOAD, W_MAX));
    send_item(uniform_item(OP_MUL, Q_ONE));
    send_item(uniform_item(OP_LOAD, W_MIN));
    send_item(uniform_item(OP_MUL, W_MIN));
    send_item(uniform_item(OP_LOAD, W_MIN));
    send_item(uniform_item(OP_TMUL, W_MAX));
    send_item(vec_item(W_MAX, W_MAX, W_MAX));
    send_item(uniform_item(OP_LOAD, 32'shaaaa_aaaa));
    send_item(uniform_item(OP_MUL, 32'sh5555_5555));
    send_item(diag_item(OP_LOAD, -Q_ONE, Q_ONE >>> 2));
    send_item(diag_item(OP_TMUL, Q_ONE, Q_ONE));
    send_item(vec_item(-Q_HALF, Q_ONE, 32'sh7fff));
    drain();

    // Random part: a load followed by a few transforms, with some stray items.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      max_gap = (phase == 0) ? 0 : $urandom_range(1, 6);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(rand_item(op_t'($urandom_range(0, 3))));
          sent++;
        end else begin
          send_item(rand_item(OP_LOAD));
          sent++;
          seq_len = $urandom_range(1, 6);
          repeat (seq_len) begin
            send_item(rand_item(op_t'($urandom_range(1, 3))));
            sent++;
          end
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("matrix3_transform_unit_core test passed");
    end else begin
      $display("matrix3_transform_unit_core test failed");
    end
    $finish;
  end

endmodule
